// File: src/assert_macros.svh
// Assertion macros shared by the LCD timing RTL.
// Needs clk and rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/lcdt_pkg.sv
// Package for the LCD register file and line timing block.
// Types, register map and timing constants; no dependencies.
`default_nettype none

package lcdt_pkg;

    localparam logic [8:0] DOTS_PER_LINE = 9'd456;
    localparam logic [7:0] LAST_LINE     = 8'd153;
    localparam logic [7:0] VBLANK_LINE   = 8'd144;
    localparam logic [8:0] OAM_END_DOT   = 9'd80;
    localparam logic [8:0] XFER_END_DOT  = 9'd252;
    localparam logic [7:0] WX_MAX        = 8'd166;
    localparam logic [11:0] REG_BASE_HI  = 12'hFF4;
    localparam logic [7:0] OPEN_BUS      = 8'hFF;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_READ  = 2'd1,
        OP_WRITE = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        MODE_HBLANK = 2'd0,
        MODE_VBLANK = 2'd1,
        MODE_OAM    = 2'd2,
        MODE_XFER   = 2'd3
    } mode_t;

    typedef enum logic [3:0] {
        REG_LCDC = 4'h0,
        REG_STAT = 4'h1,
        REG_SCY  = 4'h2,
        REG_SCX  = 4'h3,
        REG_LY   = 4'h4,
        REG_LYC  = 4'h5,
        REG_DMA  = 4'h6,
        REG_BGP  = 4'h7,
        REG_OBP0 = 4'h8,
        REG_OBP1 = 4'h9,
        REG_WY   = 4'hA,
        REG_WX   = 4'hB
    } reg_idx_t;

    // Register values the timing logic needs.
    typedef struct packed {
        logic [7:0] lcdc;
        logic [3:0] stat_en;   // STAT bits 6:3
        logic [7:0] lyc;
        logic [7:0] wy;
        logic [7:0] wx;
    } cfg_t;

    // Timing state visible through the register file.
    typedef struct packed {
        logic [7:0] ly;
        logic       coinc;
        mode_t      mode;
    } tstat_t;

endpackage

`default_nettype wire

// File: src/lcdt_if.sv
// Request and response channel interfaces for the LCD timing block.
// Uses plain logic fields only; does not depend on lcdt_pkg.
`default_nettype none

interface lcdt_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic [8:0]  dot_count;

    modport source (output valid, output opcode, output address, output write_data,
                    output dot_count, input ready);
    modport sink   (input valid, input opcode, input address, input write_data,
                    input dot_count, output ready);
endinterface

interface lcdt_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       vblank_pulse;
    logic       stat_pulse;
    logic       frame_done;
    logic [1:0] lcd_mode;
    logic [7:0] window_lines;
    logic       dma_start;

    modport source (output valid, output read_data, output vblank_pulse,
                    output stat_pulse, output frame_done, output lcd_mode,
                    output window_lines, output dma_start, input ready);
    modport sink   (input valid, input read_data, input vblank_pulse,
                    input stat_pulse, input frame_done, input lcd_mode,
                    input window_lines, input dma_start, output ready);
endinterface

`default_nettype wire

// File: src/lcdt_regfile.sv
// LCD register file: bus decode, read mux and writable registers.
// Depends on lcdt_pkg; LY and STAT low bits come from lcdt_timing.
`default_nettype none

module lcdt_regfile (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           en,
    input  wire logic [1:0]     opcode,
    input  wire logic [15:0]    address,
    input  wire logic [7:0]     write_data,
    input  wire lcdt_pkg::tstat_t tstat,
    output lcdt_pkg::cfg_t      cfg,
    output logic [7:0]          read_data,
    output logic                dma_start
);

    logic [7:0] lcdc_reg, scy_reg, scx_reg, lyc_reg, dma_reg;
    logic [7:0] bgp_reg, obp0_reg, obp1_reg, wy_reg, wx_reg;
    logic [3:0] stat_en_reg;
    logic       hit;
    logic       is_write;
    lcdt_pkg::reg_idx_t idx;

    assign hit      = (address[15:4] == lcdt_pkg::REG_BASE_HI) && (address[3:0] <= 4'hB);
    assign idx      = lcdt_pkg::reg_idx_t'(address[3:0]);
    assign is_write = (opcode == lcdt_pkg::OP_WRITE) && hit;

    always_comb
    begin
        read_data = 8'h00;
        if (opcode == lcdt_pkg::OP_READ)
        begin
            if (!hit)
            begin
                read_data = lcdt_pkg::OPEN_BUS;
            end
            else
            begin
                unique case (idx)
                    lcdt_pkg::REG_LCDC: read_data = lcdc_reg;
                    lcdt_pkg::REG_STAT: read_data = {1'b1, stat_en_reg, tstat.coinc,
                                                     tstat.mode};
                    lcdt_pkg::REG_SCY:  read_data = scy_reg;
                    lcdt_pkg::REG_SCX:  read_data = scx_reg;
                    lcdt_pkg::REG_LY:   read_data = tstat.ly;
                    lcdt_pkg::REG_LYC:  read_data = lyc_reg;
                    lcdt_pkg::REG_DMA:  read_data = dma_reg;
                    lcdt_pkg::REG_BGP:  read_data = bgp_reg;
                    lcdt_pkg::REG_OBP0: read_data = obp0_reg;
                    lcdt_pkg::REG_OBP1: read_data = obp1_reg;
                    lcdt_pkg::REG_WY:   read_data = wy_reg;
                    lcdt_pkg::REG_WX:   read_data = wx_reg;
                    default:            read_data = lcdt_pkg::OPEN_BUS;
                endcase
            end
        end
    end

    assign dma_start = is_write && (idx == lcdt_pkg::REG_DMA);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lcdc_reg    <= '0;
            stat_en_reg <= '0;
            scy_reg     <= '0;
            scx_reg     <= '0;
            lyc_reg     <= '0;
            dma_reg     <= '0;
            bgp_reg     <= '0;
            obp0_reg    <= '0;
            obp1_reg    <= '0;
            wy_reg      <= '0;
            wx_reg      <= '0;
        end
        else if (en && is_write)
        begin
            unique case (idx)
                lcdt_pkg::REG_LCDC: lcdc_reg    <= write_data;
                lcdt_pkg::REG_STAT: stat_en_reg <= write_data[6:3];
                lcdt_pkg::REG_SCY:  scy_reg     <= write_data;
                lcdt_pkg::REG_SCX:  scx_reg     <= write_data;
                lcdt_pkg::REG_LYC:  lyc_reg     <= write_data;
                lcdt_pkg::REG_DMA:  dma_reg     <= write_data;
                lcdt_pkg::REG_BGP:  bgp_reg     <= write_data;
                lcdt_pkg::REG_OBP0: obp0_reg    <= write_data;
                lcdt_pkg::REG_OBP1: obp1_reg    <= write_data;
                lcdt_pkg::REG_WY:   wy_reg      <= write_data;
                lcdt_pkg::REG_WX:   wx_reg      <= write_data;
                default:            ;  // LY is read only
            endcase
        end
    end

    assign cfg.lcdc    = lcdc_reg;
    assign cfg.stat_en = stat_en_reg;
    assign cfg.lyc     = lyc_reg;
    assign cfg.wy      = wy_reg;
    assign cfg.wx      = wx_reg;

endmodule

`default_nettype wire

// File: src/lcdt_timing.sv
// LCD line timing: dot counter, LY, mode, LY=LYC flag, window line count, pulses.
// Depends on lcdt_pkg and assert_macros.svh; register values from lcdt_regfile.
`default_nettype none
`include "assert_macros.svh"

module lcdt_timing (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           en,
    input  wire logic [1:0]     opcode,
    input  wire logic [8:0]     dot_count,
    input  wire lcdt_pkg::cfg_t cfg,
    output lcdt_pkg::tstat_t    tstat,
    output lcdt_pkg::mode_t     mode_next,
    output logic [7:0]          wl_next,
    output logic                vblank_pulse,
    output logic                stat_pulse,
    output logic                frame_done
);

    logic [8:0]      dot_reg, dot_next;
    logic [7:0]      ly_reg, ly_next;
    lcdt_pkg::mode_t mode_reg;
    logic            coinc_reg, coinc_next;
    logic [7:0]      wl_reg, wl_base;
    logic [9:0]      sum, over;
    logic            tick, wrap, changed, match, mode_irq, win_inc;
    lcdt_pkg::mode_t mode_calc;

    assign tick = (opcode == lcdt_pkg::OP_TICK);
    assign sum  = {1'b0, dot_reg} + {1'b0, dot_count};
    assign wrap = sum >= {1'b0, lcdt_pkg::DOTS_PER_LINE};
    assign over = sum - {1'b0, lcdt_pkg::DOTS_PER_LINE};

    always_comb
    begin
        dot_next   = dot_reg;
        ly_next    = ly_reg;
        frame_done = 1'b0;
        if (tick)
        begin
            if (!wrap)
            begin
                dot_next = sum[8:0];
            end
            else
            begin
                dot_next = (over >= {1'b0, lcdt_pkg::DOTS_PER_LINE}) ?
                           (lcdt_pkg::DOTS_PER_LINE - 9'd1) : over[8:0];
                if (ly_reg >= lcdt_pkg::LAST_LINE)
                begin
                    ly_next    = 8'd0;
                    frame_done = 1'b1;
                end
                else
                begin
                    ly_next = ly_reg + 8'd1;
                end
            end
        end
    end

    always_comb
    begin
        priority if (ly_next >= lcdt_pkg::VBLANK_LINE)
            mode_calc = lcdt_pkg::MODE_VBLANK;
        else if (dot_next < lcdt_pkg::OAM_END_DOT)
            mode_calc = lcdt_pkg::MODE_OAM;
        else if (dot_next < lcdt_pkg::XFER_END_DOT)
            mode_calc = lcdt_pkg::MODE_XFER;
        else
            mode_calc = lcdt_pkg::MODE_HBLANK;
    end

    assign changed   = tick && (mode_calc != mode_reg);
    assign mode_next = tick ? mode_calc : mode_reg;
    assign match     = (ly_next == cfg.lyc);
    assign coinc_next = tick ? match : coinc_reg;

    always_comb
    begin
        unique case (mode_calc)
            lcdt_pkg::MODE_HBLANK: mode_irq = cfg.stat_en[0];
            lcdt_pkg::MODE_VBLANK: mode_irq = cfg.stat_en[1];
            lcdt_pkg::MODE_OAM:    mode_irq = cfg.stat_en[2];
            default:               mode_irq = 1'b0;
        endcase
    end

    assign stat_pulse   = (changed && mode_irq) ||
                          (tick && match && !coinc_reg && cfg.stat_en[3]);
    assign vblank_pulse = changed && (mode_calc == lcdt_pkg::MODE_VBLANK);

    assign win_inc = changed && (mode_calc == lcdt_pkg::MODE_HBLANK) && cfg.lcdc[5] &&
                     (ly_next >= cfg.wy) && (cfg.wx <= lcdt_pkg::WX_MAX);
    assign wl_base = frame_done ? 8'd0 : wl_reg;
    assign wl_next = win_inc ? (wl_base + 8'd1) : wl_base;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_reg   <= '0;
            ly_reg    <= '0;
            mode_reg  <= lcdt_pkg::MODE_HBLANK;
            coinc_reg <= 1'b0;
            wl_reg    <= '0;
        end
        else if (en)
        begin
            dot_reg   <= dot_next;
            ly_reg    <= ly_next;
            mode_reg  <= mode_next;
            coinc_reg <= coinc_next;
            wl_reg    <= wl_next;
        end
    end

    assign tstat.ly    = ly_reg;
    assign tstat.coinc = coinc_reg;
    assign tstat.mode  = mode_reg;

    `ASSERT_ALWAYS(a_dot_range, dot_reg < lcdt_pkg::DOTS_PER_LINE, "dot counter past line end")
    `ASSERT_ALWAYS(a_ly_range, ly_reg <= lcdt_pkg::LAST_LINE, "LY past last line")
    `ASSERT_IMPLIES(a_vblank_mode, ly_reg >= lcdt_pkg::VBLANK_LINE,
                    mode_reg == lcdt_pkg::MODE_VBLANK, "VBlank line outside VBlank mode")
    `ASSERT_NEXT(a_frame_ly, en && frame_done, ly_reg == 8'd0, "frame wrap left LY nonzero")

endmodule

`default_nettype wire

// File: src/lcd_register_file_and_line_timing.sv
// Top level of the LCD register file and line timing block.
// Depends on lcdt_pkg, lcdt_if, lcdt_regfile, lcdt_timing, assert_macros.svh.
//
//  channel  dir  handshake    payload
//  req      in   valid/ready  opcode, address, write_data, dot_count
//  rsp      out  valid/ready  read_data, pulses, lcd_mode, window_lines, dma_start
//
// One request per cycle unless stalled; response appears in the cycle after acceptance.
// Decode, dot add/compare and mode derivation sit between request and response register.
// req.ready is low only while a response is held and rsp.ready is low.
// Reset zeroes all but the response data registers; no other start-up sequence.
`default_nettype none
`include "assert_macros.svh"

module lcd_register_file_and_line_timing (
    input  wire logic clk,
    input  wire logic rst_n,
    lcdt_req_if.sink   req,
    lcdt_rsp_if.source rsp
);

    logic             accept;
    logic             valid_reg;
    lcdt_pkg::cfg_t   cfg;
    lcdt_pkg::tstat_t tstat;
    lcdt_pkg::mode_t  mode_next;
    logic [7:0]       wl_next, rdata;
    logic             vbl, stat, frame, dma;

    logic [7:0] read_data_reg, window_lines_reg;
    logic [1:0] lcd_mode_reg;
    logic       vblank_reg, stat_reg, frame_reg, dma_reg;

    assign req.ready = !valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    lcdt_regfile u_regfile (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (accept),
        .opcode     (req.opcode),
        .address    (req.address),
        .write_data (req.write_data),
        .tstat      (tstat),
        .cfg        (cfg),
        .read_data  (rdata),
        .dma_start  (dma)
    );

    lcdt_timing u_timing (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (accept),
        .opcode       (req.opcode),
        .dot_count    (req.dot_count),
        .cfg          (cfg),
        .tstat        (tstat),
        .mode_next    (mode_next),
        .wl_next      (wl_next),
        .vblank_pulse (vbl),
        .stat_pulse   (stat),
        .frame_done   (frame)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            read_data_reg    <= rdata;
            vblank_reg       <= vbl;
            stat_reg         <= stat;
            frame_reg        <= frame;
            lcd_mode_reg     <= mode_next;
            window_lines_reg <= wl_next;
            dma_reg          <= dma;
        end
    end

    assign rsp.valid        = valid_reg;
    assign rsp.read_data    = read_data_reg;
    assign rsp.vblank_pulse = vblank_reg;
    assign rsp.stat_pulse   = stat_reg;
    assign rsp.frame_done   = frame_reg;
    assign rsp.lcd_mode     = lcd_mode_reg;
    assign rsp.window_lines = window_lines_reg;
    assign rsp.dma_start    = dma_reg;

    `ASSERT_NEXT(a_accept_valid, accept, valid_reg, "accepted request produced no response")
    `ASSERT_NEXT(a_mode_shown, accept, lcd_mode_reg == tstat.mode, "response mode mismatch")
    `ASSERT_IMPLIES(a_one_pulse_src, valid_reg && dma_reg,
                    !vblank_reg && !stat_reg && !frame_reg, "DMA write raised timing pulse")

endmodule

`default_nettype wire
